// ----- rtl/longest_repeat_k_times_macros.svh -----
// ----------------------------------------------------------------------------
// Longest repeat macros
// Assertion macros used by the top level of the longest-repeat block.
// ----------------------------------------------------------------------------
`ifndef LONGEST_REPEAT_K_TIMES_MACROS_SVH
`define LONGEST_REPEAT_K_TIMES_MACROS_SVH

`ifndef SYNTH
`define LRK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LRK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LRK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LRK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/lrk_pkg.sv -----
// ----------------------------------------------------------------------------
// Longest repeat package
// Sizes, constants and control structs of the longest-repeat block.
// ----------------------------------------------------------------------------
package lrk_pkg;

    localparam int MAX_LEN   = 1023;
    localparam int SYM_W     = 8;
    localparam int CFG_W     = 10;
    localparam int OUT_LEN_W = 10;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int VAL_W     = (LEN_W > SYM_W + 1) ? LEN_W : SYM_W + 1;
    localparam int CNT_W     = VAL_W + 1;
    localparam int BKT_DEPTH = 1 << VAL_W;
    localparam int SYM_SPAN  = (1 << SYM_W) + 1;
    localparam int CMP_W     = (LEN_W > CFG_W) ? LEN_W : CFG_W;

    localparam logic [CFG_W-1:0] MIN_REPEATS_RST = CFG_W'(2);

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [SYM_W-1:0] data;
    } lrk_load_t;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] m;
    } lrk_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [LEN_W-1:0] best;
    } lrk_stat_t;

endpackage

// ----- rtl/lrk_in_if.sv -----
// ----------------------------------------------------------------------------
// Longest repeat input channel
// Valid/ready channel that carries one symbol item of the string.
// ----------------------------------------------------------------------------
interface lrk_in_if;
    import lrk_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

// ----- rtl/lrk_out_if.sv -----
// ----------------------------------------------------------------------------
// Longest repeat output channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface lrk_out_if;
    import lrk_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_LEN_W-1:0] length;
    logic                 found;
    logic                 overflow;

    modport source (output valid, output length, output found, output overflow, input ready);
    modport sink (input valid, input length, input found, input overflow, output ready);
endinterface

// ----- rtl/lrk_ram.sv -----
// ----------------------------------------------------------------------------
// Longest repeat RAM
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module lrk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/lrk_core.sv -----
// ----------------------------------------------------------------------------
// Longest repeat core
// Sequencer over the working RAMs: suffix sort by prefix doubling with
// counting passes, Kasai LCP, then a binary search on the repeat length.
// ----------------------------------------------------------------------------
module lrk_core (
    input  logic               clk,
    input  logic               rst_n,
    input  lrk_pkg::lrk_load_t load,
    input  lrk_pkg::lrk_cmd_t  cmd,
    output lrk_pkg::lrk_stat_t stat
);
    import lrk_pkg::*;

    typedef enum logic [36:0] {
        S_IDLE    = 37'b1 << 0,
        S_INIT_RD = 37'b1 << 1,
        S_INIT_WR = 37'b1 << 2,
        S_R2_RD   = 37'b1 << 3,
        S_R2_WR   = 37'b1 << 4,
        S_CLR     = 37'b1 << 5,
        S_CNT_SA  = 37'b1 << 6,
        S_CNT_KEY = 37'b1 << 7,
        S_CNT_BKT = 37'b1 << 8,
        S_CNT_WR  = 37'b1 << 9,
        S_PFX_RD  = 37'b1 << 10,
        S_PFX_WR  = 37'b1 << 11,
        S_PLC_SA  = 37'b1 << 12,
        S_PLC_KEY = 37'b1 << 13,
        S_PLC_BKT = 37'b1 << 14,
        S_PLC_WR  = 37'b1 << 15,
        S_CPY_RD  = 37'b1 << 16,
        S_CPY_WR  = 37'b1 << 17,
        S_RNK_SA  = 37'b1 << 18,
        S_RNK_KEY = 37'b1 << 19,
        S_RNK_WR  = 37'b1 << 20,
        S_RCP_RD  = 37'b1 << 21,
        S_RCP_WR  = 37'b1 << 22,
        S_INV_RD  = 37'b1 << 23,
        S_INV_WR  = 37'b1 << 24,
        S_LCP_RK  = 37'b1 << 25,
        S_LCP_POS = 37'b1 << 26,
        S_LCP_OTH = 37'b1 << 27,
        S_LCP_CHK = 37'b1 << 28,
        S_LCP_A   = 37'b1 << 29,
        S_LCP_B   = 37'b1 << 30,
        S_LCP_WR  = 37'b1 << 31,
        S_WIN_SET = 37'b1 << 32,
        S_WIN_RD  = 37'b1 << 33,
        S_WIN_EV  = 37'b1 << 34,
        S_WIN_UPD = 37'b1 << 35,
        S_DONE    = 37'b1 << 36
    } core_state_t;

    core_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] span_reg, span_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic [LEN_W-1:0] m_reg, m_next;
    logic [LEN_W-1:0] r_reg, r_next;
    logic [LEN_W-1:0] h_reg, h_next;
    logic [LEN_W-1:0] lo_reg, lo_next;
    logic [LEN_W-1:0] hi_reg, hi_next;
    logic [LEN_W-1:0] mid_reg, mid_next;
    logic [LEN_W-1:0] run_reg, run_next;
    logic             ok_reg, ok_next;
    logic             pass_reg, pass_next;
    logic [VAL_W-1:0] sum_reg, sum_next;
    logic [VAL_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] s_reg, s_next;
    logic [VAL_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] other_reg, other_next;
    logic [VAL_W-1:0] prk_reg, prk_next;
    logic [VAL_W-1:0] prk2_reg, prk2_next;
    logic [SYM_W-1:0] a_reg, a_next;

    logic [IDX_W-1:0] txt_raddr;
    logic [SYM_W-1:0] txt_rdata;
    logic             sa_we, rk_we, rk2_we, scr_we, lcp_we, bkt_we;
    logic [IDX_W-1:0] sa_waddr, rk_waddr, rk2_waddr, scr_waddr, lcp_waddr;
    logic [IDX_W-1:0] sa_raddr, rk_raddr, rk2_raddr, scr_raddr, lcp_raddr;
    logic [VAL_W-1:0] bkt_waddr, bkt_raddr;
    logic [VAL_W-1:0] sa_wdata, rk_wdata, rk2_wdata, scr_wdata, lcp_wdata, bkt_wdata;
    logic [VAL_W-1:0] sa_rdata, rk_rdata, rk2_rdata, scr_rdata, lcp_rdata, bkt_rdata;

    logic [CNT_W-1:0] cnt_inc;
    logic [IDX_W-1:0] cnt_idx;
    logic             n_last;
    logic             span_last;
    logic [CNT_W-1:0] ik;
    logic [CNT_W-1:0] ih;
    logic [CNT_W-1:0] oh;
    logic [CNT_W-1:0] mid_sum;
    logic [VAL_W-1:0] key_rdata;
    logic [LEN_W-1:0] r_new;
    logic [LEN_W-1:0] run_new;

    lrk_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_txt (
        .clk(clk), .we(load.we), .waddr(load.addr), .wdata(load.data),
        .raddr(txt_raddr), .rdata(txt_rdata)
    );
    lrk_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_sa (
        .clk(clk), .we(sa_we), .waddr(sa_waddr), .wdata(sa_wdata),
        .raddr(sa_raddr), .rdata(sa_rdata)
    );
    lrk_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_rk (
        .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
        .raddr(rk_raddr), .rdata(rk_rdata)
    );
    lrk_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_rk2 (
        .clk(clk), .we(rk2_we), .waddr(rk2_waddr), .wdata(rk2_wdata),
        .raddr(rk2_raddr), .rdata(rk2_rdata)
    );
    lrk_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_scr (
        .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
        .raddr(scr_raddr), .rdata(scr_rdata)
    );
    lrk_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_lcp (
        .clk(clk), .we(lcp_we), .waddr(lcp_waddr), .wdata(lcp_wdata),
        .raddr(lcp_raddr), .rdata(lcp_rdata)
    );
    lrk_ram #(.WIDTH(VAL_W), .DEPTH(BKT_DEPTH)) u_bkt (
        .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(bkt_raddr), .rdata(bkt_rdata)
    );

    always_comb
    begin
        cnt_inc   = cnt_reg + CNT_W'(1);
        cnt_idx   = cnt_reg[IDX_W-1:0];
        n_last    = (cnt_inc == CNT_W'(n_reg));
        span_last = (cnt_inc == span_reg);
        ik        = cnt_reg + k_reg;
        ih        = cnt_reg + CNT_W'(h_reg);
        oh        = CNT_W'(other_reg) + CNT_W'(h_reg);
        mid_sum   = CNT_W'(lo_reg) + CNT_W'(hi_reg) + CNT_W'(1);
        key_rdata = pass_reg ? rk_rdata : rk2_rdata;
        if (cnt_reg == '0)
        begin
            r_new = LEN_W'(1);
        end
        else if (rk_rdata != prk_reg || rk2_rdata != prk2_reg)
        begin
            r_new = r_reg + LEN_W'(1);
        end
        else
        begin
            r_new = r_reg;
        end
        run_new = (lcp_rdata >= VAL_W'(mid_reg)) ? run_reg + LEN_W'(1) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        span_next  = span_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        h_next     = h_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        run_next   = run_reg;
        ok_next    = ok_reg;
        pass_next  = pass_reg;
        sum_next   = sum_reg;
        key_next   = key_reg;
        s_next     = s_reg;
        pos_next   = pos_reg;
        other_next = other_reg;
        prk_next   = prk_reg;
        prk2_next  = prk2_reg;
        a_next     = a_reg;

        txt_raddr = cnt_idx;
        sa_we     = 1'b0;
        rk_we     = 1'b0;
        rk2_we    = 1'b0;
        scr_we    = 1'b0;
        lcp_we    = 1'b0;
        bkt_we    = 1'b0;
        sa_waddr  = cnt_idx;
        rk_waddr  = cnt_idx;
        rk2_waddr = cnt_idx;
        scr_waddr = cnt_idx;
        lcp_waddr = cnt_idx;
        bkt_waddr = cnt_reg[VAL_W-1:0];
        sa_raddr  = cnt_idx;
        rk_raddr  = cnt_idx;
        rk2_raddr = cnt_idx;
        scr_raddr = cnt_idx;
        lcp_raddr = cnt_idx;
        bkt_raddr = cnt_reg[VAL_W-1:0];
        sa_wdata  = '0;
        rk_wdata  = '0;
        rk2_wdata = '0;
        scr_wdata = '0;
        lcp_wdata = '0;
        bkt_wdata = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    n_next    = cmd.n;
                    m_next    = cmd.m;
                    cnt_next  = '0;
                    k_next    = CNT_W'(1);
                    span_next = (CNT_W'(cmd.n) + CNT_W'(1) > CNT_W'(SYM_SPAN))
                                ? CNT_W'(cmd.n) + CNT_W'(1) : CNT_W'(SYM_SPAN);
                    state_next = S_INIT_RD;
                end
            end
            S_INIT_RD:
            begin
                state_next = S_INIT_WR;
            end
            S_INIT_WR:
            begin
                rk_we    = 1'b1;
                rk_wdata = VAL_W'(txt_rdata) + VAL_W'(1);
                sa_we    = 1'b1;
                sa_wdata = cnt_reg[VAL_W-1:0];
                cnt_next = cnt_inc;
                state_next = S_INIT_RD;
                if (n_last)
                begin
                    cnt_next   = '0;
                    state_next = S_R2_RD;
                end
            end
            S_R2_RD:
            begin
                rk_raddr   = ik[IDX_W-1:0];
                state_next = S_R2_WR;
            end
            S_R2_WR:
            begin
                rk2_we    = 1'b1;
                rk2_wdata = (ik < CNT_W'(n_reg)) ? rk_rdata : '0;
                cnt_next  = cnt_inc;
                state_next = S_R2_RD;
                if (n_last)
                begin
                    cnt_next   = '0;
                    pass_next  = 1'b0;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                bkt_we   = 1'b1;
                cnt_next = cnt_inc;
                if (span_last)
                begin
                    cnt_next   = '0;
                    state_next = S_CNT_SA;
                end
            end
            S_CNT_SA:
            begin
                state_next = S_CNT_KEY;
            end
            S_CNT_KEY:
            begin
                rk_raddr   = sa_rdata[IDX_W-1:0];
                rk2_raddr  = sa_rdata[IDX_W-1:0];
                state_next = S_CNT_BKT;
            end
            S_CNT_BKT:
            begin
                bkt_raddr  = key_rdata;
                key_next   = key_rdata;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = key_reg;
                bkt_wdata = bkt_rdata + VAL_W'(1);
                cnt_next  = cnt_inc;
                state_next = S_CNT_SA;
                if (n_last)
                begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    state_next = S_PFX_RD;
                end
            end
            S_PFX_RD:
            begin
                state_next = S_PFX_WR;
            end
            S_PFX_WR:
            begin
                bkt_we    = 1'b1;
                bkt_wdata = sum_reg;
                sum_next  = sum_reg + bkt_rdata;
                cnt_next  = cnt_inc;
                state_next = S_PFX_RD;
                if (span_last)
                begin
                    cnt_next   = '0;
                    state_next = S_PLC_SA;
                end
            end
            S_PLC_SA:
            begin
                state_next = S_PLC_KEY;
            end
            S_PLC_KEY:
            begin
                s_next     = sa_rdata;
                rk_raddr   = sa_rdata[IDX_W-1:0];
                rk2_raddr  = sa_rdata[IDX_W-1:0];
                state_next = S_PLC_BKT;
            end
            S_PLC_BKT:
            begin
                bkt_raddr  = key_rdata;
                key_next   = key_rdata;
                state_next = S_PLC_WR;
            end
            S_PLC_WR:
            begin
                scr_we    = 1'b1;
                scr_waddr = bkt_rdata[IDX_W-1:0];
                scr_wdata = s_reg;
                bkt_we    = 1'b1;
                bkt_waddr = key_reg;
                bkt_wdata = bkt_rdata + VAL_W'(1);
                cnt_next  = cnt_inc;
                state_next = S_PLC_SA;
                if (n_last)
                begin
                    cnt_next   = '0;
                    state_next = S_CPY_RD;
                end
            end
            S_CPY_RD:
            begin
                state_next = S_CPY_WR;
            end
            S_CPY_WR:
            begin
                sa_we    = 1'b1;
                sa_wdata = scr_rdata;
                cnt_next = cnt_inc;
                state_next = S_CPY_RD;
                if (n_last)
                begin
                    cnt_next = '0;
                    if (!pass_reg)
                    begin
                        pass_next  = 1'b1;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        state_next = S_RNK_SA;
                    end
                end
            end
            S_RNK_SA:
            begin
                state_next = S_RNK_KEY;
            end
            S_RNK_KEY:
            begin
                s_next     = sa_rdata;
                rk_raddr   = sa_rdata[IDX_W-1:0];
                rk2_raddr  = sa_rdata[IDX_W-1:0];
                state_next = S_RNK_WR;
            end
            S_RNK_WR:
            begin
                scr_we    = 1'b1;
                scr_waddr = s_reg[IDX_W-1:0];
                scr_wdata = VAL_W'(r_new);
                r_next    = r_new;
                prk_next  = rk_rdata;
                prk2_next = rk2_rdata;
                cnt_next  = cnt_inc;
                state_next = S_RNK_SA;
                if (n_last)
                begin
                    cnt_next   = '0;
                    state_next = S_RCP_RD;
                end
            end
            S_RCP_RD:
            begin
                state_next = S_RCP_WR;
            end
            S_RCP_WR:
            begin
                rk_we    = 1'b1;
                rk_wdata = scr_rdata;
                cnt_next = cnt_inc;
                state_next = S_RCP_RD;
                if (n_last)
                begin
                    cnt_next = '0;
                    if (r_reg >= n_reg || k_reg >= CNT_W'(n_reg))
                    begin
                        state_next = S_INV_RD;
                    end
                    else
                    begin
                        k_next     = k_reg << 1;
                        state_next = S_R2_RD;
                    end
                end
            end
            S_INV_RD:
            begin
                state_next = S_INV_WR;
            end
            S_INV_WR:
            begin
                rk_we    = 1'b1;
                rk_waddr = sa_rdata[IDX_W-1:0];
                rk_wdata = cnt_reg[VAL_W-1:0];
                cnt_next = cnt_inc;
                state_next = S_INV_RD;
                if (n_last)
                begin
                    cnt_next   = '0;
                    h_next     = '0;
                    state_next = S_LCP_RK;
                end
            end
            S_LCP_RK:
            begin
                state_next = S_LCP_POS;
            end
            S_LCP_POS:
            begin
                pos_next = rk_rdata;
                sa_raddr = IDX_W'(rk_rdata - VAL_W'(1));
                if (rk_rdata == '0)
                begin
                    h_next     = '0;
                    cnt_next   = cnt_inc;
                    state_next = S_LCP_RK;
                    if (n_last)
                    begin
                        lo_next    = '0;
                        hi_next    = n_reg - LEN_W'(1);
                        state_next = S_WIN_SET;
                    end
                end
                else
                begin
                    state_next = S_LCP_OTH;
                end
            end
            S_LCP_OTH:
            begin
                other_next = sa_rdata;
                state_next = S_LCP_CHK;
            end
            S_LCP_CHK:
            begin
                txt_raddr = ih[IDX_W-1:0];
                if (ih < CNT_W'(n_reg) && oh < CNT_W'(n_reg))
                begin
                    state_next = S_LCP_A;
                end
                else
                begin
                    state_next = S_LCP_WR;
                end
            end
            S_LCP_A:
            begin
                a_next     = txt_rdata;
                txt_raddr  = oh[IDX_W-1:0];
                state_next = S_LCP_B;
            end
            S_LCP_B:
            begin
                if (txt_rdata == a_reg)
                begin
                    h_next     = h_reg + LEN_W'(1);
                    state_next = S_LCP_CHK;
                end
                else
                begin
                    state_next = S_LCP_WR;
                end
            end
            S_LCP_WR:
            begin
                lcp_we    = 1'b1;
                lcp_waddr = pos_reg[IDX_W-1:0];
                lcp_wdata = VAL_W'(h_reg);
                if (h_reg != '0)
                begin
                    h_next = h_reg - LEN_W'(1);
                end
                cnt_next   = cnt_inc;
                state_next = S_LCP_RK;
                if (n_last)
                begin
                    lo_next    = '0;
                    hi_next    = n_reg - LEN_W'(1);
                    state_next = S_WIN_SET;
                end
            end
            S_WIN_SET:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = LEN_W'(mid_sum >> 1);
                    cnt_next   = CNT_W'(1);
                    run_next   = '0;
                    ok_next    = 1'b0;
                    state_next = S_WIN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WIN_RD:
            begin
                state_next = S_WIN_EV;
            end
            S_WIN_EV:
            begin
                run_next = run_new;
                if (run_new >= m_reg - LEN_W'(1))
                begin
                    ok_next = 1'b1;
                end
                cnt_next   = cnt_inc;
                state_next = n_last ? S_WIN_UPD : S_WIN_RD;
            end
            S_WIN_UPD:
            begin
                if (ok_reg)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg - LEN_W'(1);
                end
                state_next = S_WIN_SET;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            span_reg  <= '0;
            k_reg     <= '0;
            n_reg     <= '0;
            m_reg     <= '0;
            r_reg     <= '0;
            h_reg     <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            mid_reg   <= '0;
            run_reg   <= '0;
            ok_reg    <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            span_reg  <= span_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            m_reg     <= m_next;
            r_reg     <= r_next;
            h_reg     <= h_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            mid_reg   <= mid_next;
            run_reg   <= run_next;
            ok_reg    <= ok_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        key_reg   <= key_next;
        s_reg     <= s_next;
        pos_reg   <= pos_next;
        other_reg <= other_next;
        prk_reg   <= prk_next;
        prk2_reg  <= prk2_next;
        a_reg     <= a_next;
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign stat.best = lo_reg;
endmodule

// ----- rtl/longest_repeat_k_times.sv -----
// ----------------------------------------------------------------------------
// Longest repeat top level
// Loads a byte string and reports the longest substring seen min_repeats times.
// ----------------------------------------------------------------------------
// Usage:
//   text_ch carries one symbol item per cycle while loading; the item with
//   last set closes the string. Symbols past MAX_LEN are dropped and flagged.
//   result_ch carries one result item per string: length, found, overflow.
//   cfg_we/cfg_wdata write min_repeats (reset 2); the user must write it
//   only while the block is idle: the block itself does not enforce it.
// Search:
//   When the string needs a full search, the core sequencer runs doubling
//   rounds, each clearing and summing span = max(n+1, 257) buckets, for at
//   most ceil(log2 n) + 1 rounds, then builds the LCP array and runs a
//   binary search of at most ceil(log2 n) steps. Short cases (min_repeats
//   above n, or of 0 or 1) skip the core and go straight to the result hold.
// Reset and stall:
//   Reset empties the string and clears the overflow flag. text_ch stays
//   stalled during the search and while a finished result waits behind a
//   result item that the receiver has not yet taken.
// ----------------------------------------------------------------------------
`include "longest_repeat_k_times_macros.svh"

module longest_repeat_k_times (
    input  logic                     clk,
    input  logic                     rst_n,
    lrk_in_if.sink                   text_ch,
    lrk_out_if.source                result_ch,
    input  logic                     cfg_we,
    input  logic [lrk_pkg::CFG_W-1:0] cfg_wdata
);
    import lrk_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD = 3'b001,
        ST_CALC = 3'b010,
        ST_HOLD = 3'b100
    } top_state_t;

    top_state_t           state_reg, state_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 ovf_reg, ovf_next;
    logic [CFG_W-1:0]     minr_reg, minr_next;
    logic [LEN_W-1:0]     pend_len_reg, pend_len_next;
    logic                 pend_found_reg, pend_found_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_LEN_W-1:0] out_len_reg, out_len_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 accept_in;
    logic                 room;
    logic [LEN_W-1:0]     n_new;
    logic [CFG_W-1:0]     m_eff;
    logic                 slot_free;
    lrk_load_t            load;
    lrk_cmd_t             cmd;
    lrk_stat_t            stat;

    lrk_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .cmd   (cmd),
        .stat  (stat)
    );

    always_comb
    begin
        accept_in = text_ch.valid && text_ch.ready;
        room      = (len_reg < LEN_W'(MAX_LEN));
        n_new     = room ? len_reg + LEN_W'(1) : len_reg;
        m_eff     = (minr_reg == '0) ? CFG_W'(1) : minr_reg;
        slot_free = !out_valid_reg || result_ch.ready;

        load.we   = accept_in && room;
        load.addr = len_reg[IDX_W-1:0];
        load.data = text_ch.symbol;

        cmd.start = 1'b0;
        cmd.n     = n_new;
        cmd.m     = LEN_W'(m_eff);

        state_next      = state_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        minr_next       = cfg_we ? cfg_wdata : minr_reg;
        pend_len_next   = pend_len_reg;
        pend_found_next = pend_found_reg;
        out_valid_next  = out_valid_reg && !result_ch.ready;
        out_len_next    = out_len_reg;
        out_found_next  = out_found_reg;
        out_ovf_next    = out_ovf_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept_in)
                begin
                    len_next = n_new;
                    ovf_next = ovf_reg || !room;
                    if (text_ch.last)
                    begin
                        if (CMP_W'(m_eff) > CMP_W'(n_new))
                        begin
                            pend_len_next   = '0;
                            pend_found_next = 1'b0;
                            state_next      = ST_HOLD;
                        end
                        else if (m_eff == CFG_W'(1))
                        begin
                            pend_len_next   = n_new;
                            pend_found_next = 1'b1;
                            state_next      = ST_HOLD;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_CALC;
                        end
                    end
                end
            end
            ST_CALC:
            begin
                if (stat.done)
                begin
                    pend_len_next   = stat.best;
                    pend_found_next = 1'b1;
                    state_next      = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = OUT_LEN_W'(pend_len_reg);
                    out_found_next = pend_found_reg;
                    out_ovf_next   = ovf_reg;
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            minr_reg      <= MIN_REPEATS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            minr_reg      <= minr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_len_reg   <= pend_len_next;
        pend_found_reg <= pend_found_next;
        out_len_reg    <= out_len_next;
        out_found_reg  <= out_found_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign text_ch.ready      = (state_reg == ST_LOAD);
    assign result_ch.valid    = out_valid_reg;
    assign result_ch.length   = out_len_reg;
    assign result_ch.found    = out_found_reg;
    assign result_ch.overflow = out_ovf_reg;

    `LRK_ASSERT_IMP(a_load_core_idle, clk, rst_n, text_ch.ready, !stat.busy)
    `LRK_ASSERT_IMP(a_done_in_calc, clk, rst_n, stat.done, state_reg == ST_CALC)
    `LRK_ASSERT_IMP(a_start_span, clk, rst_n, cmd.start, (cmd.m >= LEN_W'(2)) && (cmd.m <= cmd.n))
    `LRK_ASSERT_NXT(a_hold_flush, clk, rst_n, (state_reg == ST_HOLD) && slot_free, result_ch.valid && (len_reg == '0))
endmodule
